// ----- rtl/acan_pkg.sv -----
// ----------------------------------------------------------------------------
// acan_pkg
// Shared types and constants for the auto-calibrating axis normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package acan_pkg;

  // default raw sample width after saturation
  localparam int RAW_BITS_DEF = 16;

  // fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int VALUE_W   = 32;
  localparam int FRAC_BITS = 16;

  // quotient bits of the scaling division, magnitude at most one in q15.16
  localparam int QUO_BITS = FRAC_BITS + 1;

  // 0.02 in q15.16 units, truncated
  localparam int DEADBAND_Q16 = 1310;

  // configuration register indexes
  localparam int   CFG_IDX_W       = 1;
  localparam logic REG_IS_DIGITAL  = 1'b0;
  localparam logic REG_IS_RELATIVE = 1'b1;

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] raw_sample;
  } acan_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] scaled_value;
    logic                      changed;
  } acan_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic reb;
    logic minmax;
    logic center;
    logic prep;
    logic fix;
    logic cmp;
    logic out_load;
  } acan_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_dig;
    logic empty;
    logic div_done;
  } acan_stat_t;

endpackage

`default_nettype wire

// ----- rtl/acan_div.sv -----
// ----------------------------------------------------------------------------
// acan_div
// Restoring divider for the scaling step: q = (a * 2^16) / d with a <= d.
// ----------------------------------------------------------------------------
`default_nettype none

module acan_div import acan_pkg::*; #(
  parameter int W = RAW_BITS_DEF + 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [W-1:0]        a,
  input  wire logic [W-1:0]        d,
  output logic                     done,
  output logic [QUO_BITS-1:0]      q
);

  localparam int CNT_W = $clog2(QUO_BITS);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic                first_r, first_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [W-1:0]        rem_r, rem_nxt;
  logic [W-1:0]        d_r, d_nxt;
  logic [QUO_BITS-1:0] q_r, q_nxt;

  logic [W:0] trial;
  logic [W:0] diff;
  logic       ge;

  always_comb begin
    // first step compares the dividend top part itself, then shift one bit a step
    trial = first_r ? {1'b0, rem_r} : {rem_r, 1'b0};
    diff  = trial - {1'b0, d_r};
    ge    = (trial >= {1'b0, d_r});

    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    d_nxt     = d_r;
    q_nxt     = q_r;

    if (start) begin
      busy_nxt  = 1'b1;
      first_nxt = 1'b1;
      cnt_nxt   = '0;
      rem_nxt   = a;
      d_nxt     = d;
      q_nxt     = '0;
    end else if (busy_r) begin
      first_nxt = 1'b0;
      rem_nxt   = ge ? diff[W-1:0] : trial[W-1:0];
      q_nxt     = {q_r[QUO_BITS-2:0], ge};
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(QUO_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      first_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      first_r <= first_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign q    = q_r;

  // done only follows the last step of a running division
  assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("acan_div: done without a finished division");

endmodule

`default_nettype wire

// ----- rtl/acan_dp.sv -----
// ----------------------------------------------------------------------------
// acan_dp
// Datapath: config, range tracking, delta rebuild, scaling, deadband, output.
// ----------------------------------------------------------------------------
`default_nettype none

module acan_dp import acan_pkg::*; #(
  parameter int RAW_BITS = RAW_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic                 cfg_data,
  input  wire acan_in_t             in_data,
  input  wire acan_cmd_t            cmd,
  output acan_stat_t                stat,
  output acan_out_t                 out_data
);

  localparam int R    = RAW_BITS;
  localparam int RW   = R + 1;
  localparam int SW   = R + 2;
  localparam int NW   = SW + 1;
  localparam int PW   = VALUE_W + SW;
  localparam int SUMW = PW + 1;
  localparam int AW   = ((R > SAMPLE_W) ? R : SAMPLE_W) + 1;
  localparam int DW   = ((R + FRAC_BITS) > VALUE_W) ? (R + FRAC_BITS) : VALUE_W;
  localparam int CW   = VALUE_W + 1;

  localparam logic signed [R-1:0]    RAW_MAX   = {1'b0, {(R-1){1'b1}}};
  localparam logic signed [R-1:0]    RAW_MIN   = {1'b1, {(R-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] S32_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] S32_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [SUMW-1:0] TRUNC_ADJ = SUMW'((1 << (FRAC_BITS + 1)) - 1);
  localparam logic signed [CW-1:0]   DB        = CW'(DEADBAND_Q16);
  localparam logic signed [RW-1:0]   ONE_RW    = RW'(1);

  function automatic logic signed [R-1:0] sat_acc(input logic signed [AW-1:0] v);
    logic signed [R-1:0] res;
    if (v > RAW_MAX) begin
      res = RAW_MAX;
    end else if (v < RAW_MIN) begin
      res = RAW_MIN;
    end else begin
      res = v[R-1:0];
    end
    return res;
  endfunction

  // registers
  logic                       is_dig_r, is_dig_nxt;
  logic                       is_rel_r, is_rel_nxt;
  logic signed [RW-1:0]       lo_r, lo_nxt;
  logic signed [RW-1:0]       hi_r, hi_nxt;
  logic signed [VALUE_W-1:0]  cur_r, cur_nxt;
  logic                       chg_r, chg_nxt;
  logic signed [SAMPLE_W-1:0] sample_r, sample_nxt;
  logic signed [R-1:0]        raw_r, raw_nxt;
  logic signed [PW-1:0]       prod_r, prod_nxt;
  logic signed [VALUE_W-1:0]  cand_r, cand_nxt;
  logic                       neg_r, neg_nxt;
  acan_out_t                  out_r, out_nxt;

  // combinational terms
  logic signed [SW-1:0]       sum_hl, dif_hl;
  logic signed [SUMW-1:0]     reb_sum, reb_adj, reb_q;
  logic signed [R-1:0]        prev_sat;
  logic signed [AW-1:0]       acc;
  logic signed [R-1:0]        ld_raw;
  logic signed [RW-1:0]       raw_ext, neg_lo, neg_hi;
  logic signed [NW-1:0]       num, num_abs;
  logic                       empty;
  logic signed [DW-1:0]       dig_w;
  logic signed [VALUE_W-1:0]  cand_dig;
  logic signed [VALUE_W-1:0]  qx;
  logic signed [CW-1:0]       dlt;
  logic                       upd;
  logic                       div_start;
  logic                       div_done;
  logic [QUO_BITS-1:0]        div_q;

  assign sum_hl = SW'(hi_r) + SW'(lo_r);
  assign dif_hl = SW'(hi_r) - SW'(lo_r);

  always_comb begin
    // raw value rebuilt from the stored value, truncated toward zero
    reb_sum = SUMW'(prod_r) + (SUMW'(sum_hl) <<< FRAC_BITS);
    reb_adj = reb_sum[SUMW-1] ? TRUNC_ADJ : '0;
    reb_q   = (reb_sum + reb_adj) >>> (FRAC_BITS + 1);
    if (reb_q > RAW_MAX) begin
      prev_sat = RAW_MAX;
    end else if (reb_q < RAW_MIN) begin
      prev_sat = RAW_MIN;
    end else begin
      prev_sat = reb_q[R-1:0];
    end
    acc    = AW'(prev_sat) + AW'(sample_r);
    ld_raw = sat_acc(AW'(in_data.raw_sample));

    raw_ext = RW'(raw_r);
    neg_lo  = -lo_r;
    neg_hi  = -hi_r;

    // scaling numerator, magnitude never above the range width
    empty   = !(lo_r < hi_r);
    num     = (NW'(raw_r) <<< 1) - NW'(sum_hl);
    num_abs = num[NW-1] ? -num : num;

    dig_w = DW'(raw_r) <<< FRAC_BITS;
    if (dig_w > S32_MAX) begin
      cand_dig = S32_MAX;
    end else if (dig_w < S32_MIN) begin
      cand_dig = S32_MIN;
    end else begin
      cand_dig = dig_w[VALUE_W-1:0];
    end

    qx = VALUE_W'(div_q);

    dlt = CW'(cand_r) - CW'(cur_r);
    upd = is_rel_r || (dlt > DB) || (dlt < -DB);
  end

  assign div_start = cmd.prep && !is_dig_r && !empty;

  always_comb begin
    is_dig_nxt = is_dig_r;
    is_rel_nxt = is_rel_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    cur_nxt    = cur_r;
    chg_nxt    = chg_r;
    sample_nxt = sample_r;
    raw_nxt    = raw_r;
    prod_nxt   = prod_r;
    cand_nxt   = cand_r;
    neg_nxt    = neg_r;
    out_nxt    = out_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_IS_DIGITAL:  is_dig_nxt = cfg_data;
        REG_IS_RELATIVE: is_rel_nxt = cfg_data;
        default: ;
      endcase
    end

    if (cmd.load) begin
      sample_nxt = in_data.raw_sample;
      raw_nxt    = ld_raw;
    end
    if (cmd.mul) begin
      prod_nxt = PW'(cur_r) * PW'(dif_hl);
    end
    if (cmd.reb) begin
      raw_nxt = sat_acc(acc);
    end
    if (cmd.minmax) begin
      if (raw_ext < lo_r) lo_nxt = raw_ext;
      if (raw_ext > hi_r) hi_nxt = raw_ext;
    end
    if (cmd.center && is_rel_r) begin
      // symmetric range about zero
      if (hi_r > neg_lo) begin
        lo_nxt = neg_hi;
      end else if (hi_r < neg_lo) begin
        hi_nxt = neg_lo;
      end
    end
    if (cmd.prep) begin
      neg_nxt = num[NW-1];
      if (is_dig_r) begin
        cand_nxt = cand_dig;
      end else if (empty) begin
        chg_nxt = 1'b0;
      end
    end
    if (cmd.fix) begin
      cand_nxt = neg_r ? -qx : qx;
    end
    if (cmd.cmp) begin
      chg_nxt = upd;
      if (upd) cur_nxt = cand_r;
    end
    if (cmd.out_load) begin
      out_nxt.scaled_value = cur_r;
      out_nxt.changed      = chg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_dig_r <= 1'b0;
      is_rel_r <= 1'b0;
      lo_r     <= ONE_RW;
      hi_r     <= -ONE_RW;
      cur_r    <= '0;
    end else begin
      is_dig_r <= is_dig_nxt;
      is_rel_r <= is_rel_nxt;
      lo_r     <= lo_nxt;
      hi_r     <= hi_nxt;
      cur_r    <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chg_r    <= chg_nxt;
    sample_r <= sample_nxt;
    raw_r    <= raw_nxt;
    prod_r   <= prod_nxt;
    cand_r   <= cand_nxt;
    neg_r    <= neg_nxt;
    out_r    <= out_nxt;
  end

  acan_div #(
    .W (RW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (num_abs[RW-1:0]),
    .d     (dif_hl[RW-1:0]),
    .done  (div_done),
    .q     (div_q)
  );

  assign stat.is_dig   = is_dig_r;
  assign stat.empty    = empty;
  assign stat.div_done = div_done;
  assign out_data      = out_r;

  // stored value moves only on a deadband compare
  assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.cmp |=> $stable(cur_r))
    else $error("acan_dp: stored value changed outside compare");

  // relative axis range is symmetric once centered
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.prep && is_rel_r) |-> (hi_r == neg_lo))
    else $error("acan_dp: relative range not symmetric");

endmodule

`default_nettype wire

// ----- rtl/acan_ctrl.sv -----
// ----------------------------------------------------------------------------
// acan_ctrl
// Sequencer for one sample: rebuild, range update, scale, deadband, output.
// ----------------------------------------------------------------------------
`default_nettype none

module acan_ctrl import acan_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_kind,
  output logic            in_ready,
  input  wire logic       out_ready,
  output logic            out_valid,
  input  wire acan_stat_t stat,
  output acan_cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_REB   = 4'd2;
  localparam logic [3:0] S_RANGE = 4'd3;
  localparam logic [3:0] S_CENT  = 4'd4;
  localparam logic [3:0] S_PREP  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_FIX   = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = in_kind ? S_MUL : S_RANGE;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_REB;
      end
      S_REB: begin
        cmd.reb   = 1'b1;
        state_nxt = S_RANGE;
      end
      S_RANGE: begin
        cmd.minmax = 1'b1;
        state_nxt  = S_CENT;
      end
      S_CENT: begin
        cmd.center = 1'b1;
        state_nxt  = S_PREP;
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        if (stat.is_dig) begin
          state_nxt = S_CMP;
        end else if (stat.empty) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // a new result only appears from the output state
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("acan_ctrl: result raised outside output state");

  // an accepted request starts either the rebuild or the range update
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> ((state_r == S_MUL) || (state_r == S_RANGE)))
    else $error("acan_ctrl: accepted request not started");

endmodule

`default_nettype wire

// ----- rtl/auto_calibrating_axis_normalizer_top.sv -----
// ----------------------------------------------------------------------------
// auto_calibrating_axis_normalizer_top
// Auto-calibrating input axis: tracks min/max, scales to q15.16, deadband.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  in_      | in_valid / in_ready    | acan_in_t  {kind, raw_sample}
//  out_     | out_valid / out_ready  | acan_out_t {scaled_value, changed}
//  cfg_     | cfg_valid / cfg_ready  | cfg_index (register), cfg_data (bit 0)
//
//  one request is worked at a time: a delta is rebuilt from the stored value,
//  the range is updated (centred if relative); digital goes to compare, an
//  empty analogue range to output, else the 17-step restoring divider runs
//  the result sits in an output register, so a new request is taken while it
//  waits; the sequencer stalls only in its output state if that is still full
//  reset (rst_n low, synchronous) sets range to +1/-1, value to zero, config
//  to analogue and absolute; cfg_ready is always high
// ----------------------------------------------------------------------------
`default_nettype none

module auto_calibrating_axis_normalizer_top import acan_pkg::*; #(
  parameter int RAW_BITS = RAW_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  // sample requests
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire acan_in_t             in_data,

  // results
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output acan_out_t                 out_data,

  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic                 cfg_data
);

  acan_cmd_t  cmd;
  acan_stat_t stat;

  // config writes are always accepted and land in the config registers
  assign cfg_ready = 1'b1;

  // sequencer: owns the handshakes and steps the datapath
  acan_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: range registers, delta rebuild multiplier, divider, deadband
  acan_dp #(
    .RAW_BITS (RAW_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
